// ----- hdl/tco_pkg.sv -----
// shared types, constants and step functions for the cell outflow block
`timescale 1ns / 1ps
`default_nettype none

package tco_pkg;

   localparam int WATER_BITS    = 32;
   localparam int HEIGHT_BITS   = 16;
   localparam int DIV_BITS      = 16;
   localparam int PROD_BITS     = WATER_BITS + HEIGHT_BITS;
   localparam int NUM_NEIGH     = 8;
   localparam int COUNT_BITS    = 4;
   localparam int SREM_BITS     = COUNT_BITS - 1;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int DIV_STAGES    = 8;
   localparam int DIV_STEPS     = WATER_BITS / DIV_STAGES;
   localparam int SHARE_STAGES  = 4;
   localparam int SHARE_STEPS   = WATER_BITS / SHARE_STAGES;
   localparam int PIPE_DEPTH    = 1 + DIV_STAGES + SHARE_STAGES;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_INDEX_BIT = 2;

   localparam logic [WATER_BITS-1:0] DRY_THRESHOLD_RESET = WATER_BITS'(65);
   localparam logic [DIV_BITS-1:0]   FLOW_DIVISOR_RESET  = DIV_BITS'(3200);

   localparam logic REG_DRY_THRESHOLD = 1'b0;
   localparam logic REG_FLOW_DIVISOR  = 1'b1;

   typedef enum logic [1:0] {
      MODE_DRY,
      MODE_ALL,
      MODE_DIV
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic [WATER_BITS-1:0]   water;
      logic [HEIGHT_BITS-1:0]  drop;
      logic [NUM_NEIGH-1:0]    targets;
      logic [COUNT_BITS-1:0]   count;
   } class_type;

   typedef struct packed {
      mode_type                mode;
      logic [WATER_BITS-1:0]   water;
      logic [WATER_BITS-1:0]   acc;
      logic [DIV_BITS-1:0]     rem;
      logic [WATER_BITS-1:0]   flow;
      logic [SREM_BITS-1:0]    srem;
      logic [COUNT_BITS-1:0]   count;
      logic [NUM_NEIGH-1:0]    targets;
   } pipe_type;

   typedef struct packed {
      logic [WATER_BITS-1:0]   outflow;
      logic [WATER_BITS-1:0]   share_each;
      logic [NUM_NEIGH-1:0]    target_mask;
      logic [WATER_BITS-1:0]   water_left;
   } result_type;

   // restoring long division, quotient bits shift into acc from the bottom
   function automatic pipe_type div_stage(pipe_type p, logic [DIV_BITS-1:0] divisor);
      pipe_type           r;
      logic [DIV_BITS:0]  trial;
      r = p;
      for (int s = 0; s < DIV_STEPS; s++) begin
         trial = {r.rem, r.acc[WATER_BITS-1]};
         if (trial >= {1'b0, divisor}) begin
            r.rem = DIV_BITS'(trial - {1'b0, divisor});
            r.acc = {r.acc[WATER_BITS-2:0], 1'b1};
         end else begin
            r.rem = trial[DIV_BITS-1:0];
            r.acc = {r.acc[WATER_BITS-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   function automatic pipe_type share_stage(pipe_type p);
      pipe_type              r;
      logic [COUNT_BITS-1:0] trial;
      r = p;
      for (int s = 0; s < SHARE_STEPS; s++) begin
         trial = {r.srem, r.acc[WATER_BITS-1]};
         if (trial >= r.count) begin
            r.srem = SREM_BITS'(trial - r.count);
            r.acc  = {r.acc[WATER_BITS-2:0], 1'b1};
         end else begin
            r.srem = trial[SREM_BITS-1:0];
            r.acc  = {r.acc[WATER_BITS-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   // pick the outflow once the quotient is done and restart acc as dividend
   function automatic pipe_type load_flow(pipe_type p);
      pipe_type r;
      r = p;
      case (p.mode)
         MODE_DRY: r.flow = '0;
         MODE_ALL: r.flow = p.water;
         MODE_DIV: r.flow = p.acc;
         default:  r.flow = '0;
      endcase
      r.acc  = r.flow;
      r.srem = '0;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/terrain_cell_outflow_top.sv -----
// top level of the cell outflow block: register port, front, queue and back
// path: an accepted item passes the queue, 13 pipeline stages and an output register
// throughput: one item per cycle; the back end stalls only while a result waits to be popped
// the divider in the back end retires 4 quotient bits per stage, the target split 8 per stage
// reset: synchronous, empties queue and pipeline, loads dry_threshold 65 and flow_divisor 3200
`timescale 1ns / 1ps
`default_nettype none

module terrain_cell_outflow_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic [tco_pkg::WATER_BITS-1:0]      req_cell_water,
   input  wire logic [tco_pkg::HEIGHT_BITS-1:0]     req_own_height,
   input  wire logic [tco_pkg::HEIGHT_BITS-1:0]     req_height_nw,
   input  wire logic [tco_pkg::HEIGHT_BITS-1:0]     req_height_n,
   input  wire logic [tco_pkg::HEIGHT_BITS-1:0]     req_height_ne,
   input  wire logic [tco_pkg::HEIGHT_BITS-1:0]     req_height_w,
   input  wire logic [tco_pkg::HEIGHT_BITS-1:0]     req_height_e,
   input  wire logic [tco_pkg::HEIGHT_BITS-1:0]     req_height_sw,
   input  wire logic [tco_pkg::HEIGHT_BITS-1:0]     req_height_s,
   input  wire logic [tco_pkg::HEIGHT_BITS-1:0]     req_height_se,
   input  wire logic [tco_pkg::NUM_NEIGH-1:0]       req_neighbor_in_grid,
   output logic                                     empty,
   input  wire logic                                pop,
   output logic [tco_pkg::WATER_BITS-1:0]           rsp_outflow,
   output logic [tco_pkg::WATER_BITS-1:0]           rsp_share_each,
   output logic [tco_pkg::NUM_NEIGH-1:0]            rsp_target_mask,
   output logic [tco_pkg::WATER_BITS-1:0]           rsp_water_left,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [tco_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [tco_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [tco_pkg::CSR_DATA_BITS-1:0]        prdata,
   output logic                                     pready
);

   logic [tco_pkg::WATER_BITS-1:0]                           dry_threshold_ff;
   logic [tco_pkg::DIV_BITS-1:0]                             flow_divisor_ff;
   logic                                                     csr_write;
   logic [tco_pkg::NUM_NEIGH-1:0][tco_pkg::HEIGHT_BITS-1:0]  heights;
   tco_pkg::class_type                                       front_item;
   tco_pkg::class_type                                       head_item;
   logic                                                     queue_empty;
   logic                                                     queue_pop;
   tco_pkg::result_type                                      result;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      if (paddr[tco_pkg::REG_INDEX_BIT] == tco_pkg::REG_FLOW_DIVISOR) begin
         prdata = tco_pkg::CSR_DATA_BITS'(flow_divisor_ff);
      end else begin
         prdata = tco_pkg::CSR_DATA_BITS'(dry_threshold_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dry_threshold_ff <= tco_pkg::DRY_THRESHOLD_RESET;
         flow_divisor_ff  <= tco_pkg::FLOW_DIVISOR_RESET;
      end else if (csr_write) begin
         if (paddr[tco_pkg::REG_INDEX_BIT] == tco_pkg::REG_FLOW_DIVISOR) begin
            flow_divisor_ff <= pwdata[tco_pkg::DIV_BITS-1:0];
         end else begin
            dry_threshold_ff <= pwdata[tco_pkg::WATER_BITS-1:0];
         end
      end
   end

   assign heights = {req_height_se, req_height_s, req_height_sw, req_height_e,
                     req_height_w, req_height_ne, req_height_n, req_height_nw};

   tco_front u_front (
      .water         (req_cell_water),
      .own_height    (req_own_height),
      .heights       (heights),
      .in_grid       (req_neighbor_in_grid),
      .dry_threshold (dry_threshold_ff),
      .flow_divisor  (flow_divisor_ff),
      .item          (front_item)
   );

   tco_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (full),
      .pop       (queue_pop),
      .head_item (head_item),
      .empty     (queue_empty)
   );

   tco_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_item    (head_item),
      .queue_empty  (queue_empty),
      .queue_pop    (queue_pop),
      .flow_divisor (flow_divisor_ff),
      .result       (result),
      .result_empty (empty),
      .result_pop   (pop)
   );

   assign rsp_outflow     = result.outflow;
   assign rsp_share_each  = result.share_each;
   assign rsp_target_mask = result.target_mask;
   assign rsp_water_left  = result.water_left;

endmodule

`default_nettype wire

// ----- hdl/tco_front.sv -----
// front end: finds the lowest in-grid neighbor below the cell, the targets and the flow mode
`timescale 1ns / 1ps
`default_nettype none

module tco_front (
   input  wire logic [tco_pkg::WATER_BITS-1:0]                          water,
   input  wire logic [tco_pkg::HEIGHT_BITS-1:0]                         own_height,
   input  wire logic [tco_pkg::NUM_NEIGH-1:0][tco_pkg::HEIGHT_BITS-1:0] heights,
   input  wire logic [tco_pkg::NUM_NEIGH-1:0]                           in_grid,
   input  wire logic [tco_pkg::WATER_BITS-1:0]                          dry_threshold,
   input  wire logic [tco_pkg::DIV_BITS-1:0]                            flow_divisor,
   output tco_pkg::class_type                                           item
);

   logic [tco_pkg::NUM_NEIGH-1:0]                             lower;
   logic [tco_pkg::NUM_NEIGH-1:0][tco_pkg::HEIGHT_BITS-1:0]   cand;
   logic [3:0][tco_pkg::HEIGHT_BITS-1:0]                      lvl1;
   logic [1:0][tco_pkg::HEIGHT_BITS-1:0]                      lvl2;
   logic [tco_pkg::HEIGHT_BITS-1:0]                           hmin;
   logic [tco_pkg::HEIGHT_BITS-1:0]                           drop;
   logic [tco_pkg::NUM_NEIGH-1:0]                             targets;
   logic [tco_pkg::COUNT_BITS-1:0]                            count;

   // neighbors that are not candidates read as all ones, above any lower one
   always_comb begin
      for (int i = 0; i < tco_pkg::NUM_NEIGH; i++) begin
         lower[i] = in_grid[i] && (heights[i] < own_height);
         cand[i]  = lower[i] ? heights[i] : '1;
      end
      for (int i = 0; i < 4; i++) begin
         lvl1[i] = (cand[2*i] < cand[2*i+1]) ? cand[2*i] : cand[2*i+1];
      end
      for (int i = 0; i < 2; i++) begin
         lvl2[i] = (lvl1[2*i] < lvl1[2*i+1]) ? lvl1[2*i] : lvl1[2*i+1];
      end
      hmin = (lvl2[0] < lvl2[1]) ? lvl2[0] : lvl2[1];
      drop = own_height - hmin;
      count = '0;
      for (int i = 0; i < tco_pkg::NUM_NEIGH; i++) begin
         targets[i] = in_grid[i] && (heights[i] == hmin);
         count      = count + tco_pkg::COUNT_BITS'(targets[i]);
      end
   end

   always_comb begin
      item.water = water;
      if (!((water > dry_threshold) && (|lower))) begin
         item.mode    = tco_pkg::MODE_DRY;
         item.drop    = '0;
         item.targets = '0;
         item.count   = tco_pkg::COUNT_BITS'(1);
      end else begin
         if ((flow_divisor == '0) || (drop >= flow_divisor)) begin
            item.mode = tco_pkg::MODE_ALL;
         end else begin
            item.mode = tco_pkg::MODE_DIV;
         end
         item.drop    = drop;
         item.targets = targets;
         item.count   = count;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tco_queue.sv -----
// short queue of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none

module tco_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tco_pkg::class_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output tco_pkg::class_type      head_item,
   output logic                    empty
);

   tco_pkg::class_type               entries_ff [tco_pkg::QUEUE_DEPTH];
   logic [tco_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tco_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tco_pkg::QPTR_BITS:0]      count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full      = (count_ff == (tco_pkg::QPTR_BITS+1)'(tco_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tco_back.sv -----
// back end: multiply, pipelined divide by the divisor, split among targets
`timescale 1ns / 1ps
`default_nettype none

module tco_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tco_pkg::class_type            head_item,
   input  wire logic                          queue_empty,
   output logic                               queue_pop,
   input  wire logic [tco_pkg::DIV_BITS-1:0]  flow_divisor,
   output tco_pkg::result_type                result,
   output logic                               result_empty,
   input  wire logic                          result_pop
);

   tco_pkg::pipe_type                 pipe_ff [tco_pkg::PIPE_DEPTH];
   tco_pkg::pipe_type                 pipe_in [tco_pkg::PIPE_DEPTH];
   logic [tco_pkg::PIPE_DEPTH-1:0]    valid_ff, valid_in;
   tco_pkg::result_type               out_ff, out_in;
   logic                              out_valid_ff;
   logic                              advance;
   logic [tco_pkg::PROD_BITS-1:0]     prod;
   tco_pkg::pipe_type                 last;

   // whole pipeline moves together; it holds only while a result waits
   assign advance      = !out_valid_ff || result_pop;
   assign queue_pop    = advance && !queue_empty;
   assign result       = out_ff;
   assign result_empty = !out_valid_ff;

   always_comb begin
      prod = head_item.water * head_item.drop;
      pipe_in[0].mode    = head_item.mode;
      pipe_in[0].water   = head_item.water;
      pipe_in[0].acc     = prod[tco_pkg::WATER_BITS-1:0];
      pipe_in[0].rem     = prod[tco_pkg::PROD_BITS-1:tco_pkg::WATER_BITS];
      pipe_in[0].flow    = '0;
      pipe_in[0].srem    = '0;
      pipe_in[0].count   = head_item.count;
      pipe_in[0].targets = head_item.targets;
      for (int k = 1; k < tco_pkg::PIPE_DEPTH; k++) begin
         if (k <= tco_pkg::DIV_STAGES) begin
            pipe_in[k] = tco_pkg::div_stage(pipe_ff[k-1], flow_divisor);
         end else if (k == tco_pkg::DIV_STAGES + 1) begin
            pipe_in[k] = tco_pkg::share_stage(tco_pkg::load_flow(pipe_ff[k-1]));
         end else begin
            pipe_in[k] = tco_pkg::share_stage(pipe_ff[k-1]);
         end
      end
      valid_in = {valid_ff[tco_pkg::PIPE_DEPTH-2:0], !queue_empty};
   end

   always_comb begin
      last                = pipe_ff[tco_pkg::PIPE_DEPTH-1];
      out_in.outflow      = last.flow;
      out_in.share_each   = last.acc;
      out_in.target_mask  = last.targets;
      out_in.water_left   = last.water - last.flow;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[tco_pkg::PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < tco_pkg::PIPE_DEPTH; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tco_checker.sv -----
// port-level checks for the cell outflow block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module tco_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              empty,
   input wire logic                              pop,
   input wire logic [tco_pkg::WATER_BITS-1:0]    rsp_outflow,
   input wire logic [tco_pkg::WATER_BITS-1:0]    rsp_share_each,
   input wire logic [tco_pkg::NUM_NEIGH-1:0]     rsp_target_mask,
   input wire logic [tco_pkg::WATER_BITS-1:0]    rsp_water_left
);

   // nothing waits right after reset
   assert property (@(posedge clock) reset |=> empty)
      else $error("result shown right after reset");

   // no targets means nothing flowed
   assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_target_mask == '0)) |-> ((rsp_outflow == '0) &&
                                               (rsp_share_each == '0)))
      else $error("outflow without targets");

   // a single target takes the whole outflow
   assert property (@(posedge clock) disable iff (reset)
      (!empty && ($countones(rsp_target_mask) == 1)) |-> (rsp_share_each == rsp_outflow))
      else $error("single target share differs from outflow");

   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_share_each <= rsp_outflow))
      else $error("share larger than outflow");

   // a waiting result holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_outflow) && $stable(rsp_water_left)))
      else $error("waiting result changed");

endmodule

bind terrain_cell_outflow_top tco_checker u_checker (.*);

`default_nettype wire
